@@ rtl/core/csac_pkg.sv @@
// Shared constants, command and status types for the clipped square average color block.
`timescale 1ns / 1ps

package csac_pkg;

  // Largest image held in the pixel store
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  // Derived sizes
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 8;
  localparam int STEP_W = 3;

  // Fixed field widths
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 9;
  localparam int CFG_W   = 9;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int DIM_W   = COORD_W + 1;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic item_load;
    logic eval;
    logic write_en;
    logic scan_en;
    logic div_load;
    logic div_step;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic in_range;
    logic query_empty;
    logic scan_last;
    logic div_last;
  } sts_t;

endpackage

@@ rtl/core/csac_ctrl.sv @@
// Controller state machine: clearing pass, item sequencing and result handoff.
`timescale 1ns / 1ps

module csac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  csac_pkg::sts_t    sts,
  output csac_pkg::cmd_t    cmd
);

  csac_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             res_free;

  assign res_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csac_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = csac_pkg::ST_IDLE;
      end
      csac_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = csac_pkg::ST_EVAL;
      end
      csac_pkg::ST_EVAL: begin
        if (sts.is_query && !sts.query_empty) state_nxt = csac_pkg::ST_SCAN;
        else state_nxt = csac_pkg::ST_RESULT;
      end
      csac_pkg::ST_SCAN: begin
        if (sts.scan_last) state_nxt = csac_pkg::ST_DRAIN;
      end
      csac_pkg::ST_DRAIN:    state_nxt = csac_pkg::ST_DIV_LOAD;
      csac_pkg::ST_DIV_LOAD: state_nxt = csac_pkg::ST_DIVIDE;
      csac_pkg::ST_DIVIDE: begin
        if (sts.div_last) state_nxt = csac_pkg::ST_RESULT;
      end
      csac_pkg::ST_RESULT: begin
        if (res_free) state_nxt = csac_pkg::ST_IDLE;
      end
      default: state_nxt = csac_pkg::ST_CLEAR;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd           = '0;
    cmd.clr_en    = (state_r == csac_pkg::ST_CLEAR);
    cmd.item_load = (state_r == csac_pkg::ST_IDLE) && in_valid;
    cmd.eval      = (state_r == csac_pkg::ST_EVAL);
    cmd.write_en  = (state_r == csac_pkg::ST_EVAL) && !sts.is_query && sts.in_range;
    cmd.scan_en   = (state_r == csac_pkg::ST_SCAN);
    cmd.div_load  = (state_r == csac_pkg::ST_DIV_LOAD);
    cmd.div_step  = (state_r == csac_pkg::ST_DIVIDE);
    cmd.res_load  = (state_r == csac_pkg::ST_RESULT) && res_free;
  end

  assign in_ready  = (state_r == csac_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // Hold the result until the output transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csac_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A new result never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending output");

  // The scan keeps going until the last pixel of the region is issued
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csac_pkg::ST_SCAN) && !sts.scan_last |=> (state_r == csac_pkg::ST_SCAN))
    else $error("scan left early");

  // The store is written only after the clearing pass and only in range
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_en |-> (sts.in_range && !cmd.clr_en))
    else $error("pixel write out of range or during clear");

endmodule

@@ rtl/core/csac_dp.sv @@
// Datapath: configuration, pixel store, region scan, accumulators and serial divider.
`timescale 1ns / 1ps

module csac_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [csac_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_opcode,
  input  logic [csac_pkg::COORD_W-1:0]      in_x,
  input  logic [csac_pkg::COORD_W-1:0]      in_y,
  input  logic [csac_pkg::SIZE_W-1:0]       in_size,
  input  logic [csac_pkg::CHAN_W-1:0]       in_red_in,
  input  logic [csac_pkg::CHAN_W-1:0]       in_green_in,
  input  logic [csac_pkg::CHAN_W-1:0]       in_blue_in,
  output logic                              out_ok,
  output logic [csac_pkg::CHAN_W-1:0]       out_red_out,
  output logic [csac_pkg::CHAN_W-1:0]       out_green_out,
  output logic [csac_pkg::CHAN_W-1:0]       out_blue_out,
  input  csac_pkg::cmd_t                    cmd,
  output csac_pkg::sts_t                    sts
);

  // Configuration registers
  logic [csac_pkg::CFG_W-1:0] img_w_r, img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= csac_pkg::CFG_RESET;
      img_h_r <= csac_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csac_pkg::REG_IMAGE_WIDTH:  img_w_r <= cfg_data;
        csac_pkg::REG_IMAGE_HEIGHT: img_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latched transaction
  logic                              op_r;
  logic [csac_pkg::COORD_W-1:0]      x_r, y_r;
  logic [csac_pkg::SIZE_W-1:0]       size_r;
  logic [csac_pkg::PIX_W-1:0]        pix_r;

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      op_r   <= in_opcode;
      x_r    <= in_x;
      y_r    <= in_y;
      size_r <= in_size;
      pix_r  <= {in_red_in, in_green_in, in_blue_in};
    end
  end

  // Clip against the effective image size
  logic [csac_pkg::DIM_W-1:0] eff_w, eff_h, ex, ey, ex_c, ey_c;
  logic                       x_ok, y_ok;

  always_comb begin
    eff_w = (csac_pkg::DIM_W'(img_w_r) > csac_pkg::DIM_W'(csac_pkg::MAX_WIDTH))
            ? csac_pkg::DIM_W'(csac_pkg::MAX_WIDTH) : csac_pkg::DIM_W'(img_w_r);
    eff_h = (csac_pkg::DIM_W'(img_h_r) > csac_pkg::DIM_W'(csac_pkg::MAX_HEIGHT))
            ? csac_pkg::DIM_W'(csac_pkg::MAX_HEIGHT) : csac_pkg::DIM_W'(img_h_r);
    x_ok  = csac_pkg::DIM_W'(x_r) < eff_w;
    y_ok  = csac_pkg::DIM_W'(y_r) < eff_h;
    ex    = csac_pkg::DIM_W'(x_r) + csac_pkg::DIM_W'(size_r);
    ey    = csac_pkg::DIM_W'(y_r) + csac_pkg::DIM_W'(size_r);
    ex_c  = (ex > eff_w) ? eff_w : ex;
    ey_c  = (ey > eff_h) ? eff_h : ey;
  end

  // Region scan counters
  logic [csac_pkg::COL_W-1:0] col_r, x_start_r, ex_last_r;
  logic [csac_pkg::ROW_W-1:0] row_r, ey_last_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      col_r     <= csac_pkg::COL_W'(x_r);
      x_start_r <= csac_pkg::COL_W'(x_r);
      row_r     <= csac_pkg::ROW_W'(y_r);
      ex_last_r <= csac_pkg::COL_W'(ex_c - 1'b1);
      ey_last_r <= csac_pkg::ROW_W'(ey_c - 1'b1);
    end else if (cmd.scan_en) begin
      if (col_r == ex_last_r) begin
        col_r <= x_start_r;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else rd_vld_r <= cmd.scan_en;
  end

  // Clearing pass address
  logic [csac_pkg::ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr_en) clr_addr_r <= clr_addr_r + 1'b1;
  end

  // Pixel store: one write port, one registered read port
  logic [csac_pkg::PIX_W-1:0]  mem [csac_pkg::DEPTH];
  logic [csac_pkg::PIX_W-1:0]  mem_q;
  logic [csac_pkg::ADDR_W-1:0] wr_addr, rd_addr, mem_waddr;
  logic [csac_pkg::PIX_W-1:0]  mem_wdata;
  logic                        mem_we;

  assign wr_addr = csac_pkg::ADDR_W'(csac_pkg::ROW_W'(y_r))
                   * csac_pkg::ADDR_W'(csac_pkg::MAX_WIDTH)
                   + csac_pkg::ADDR_W'(csac_pkg::COL_W'(x_r));
  assign rd_addr = csac_pkg::ADDR_W'(row_r) * csac_pkg::ADDR_W'(csac_pkg::MAX_WIDTH)
                   + csac_pkg::ADDR_W'(col_r);
  assign mem_we    = cmd.clr_en || cmd.write_en;
  assign mem_waddr = cmd.clr_en ? clr_addr_r : wr_addr;
  assign mem_wdata = cmd.clr_en ? '0 : pix_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[rd_addr];
  end

  // Per-channel sums and pixel count
  logic [csac_pkg::SUM_W-1:0] sum_r [3];
  logic [csac_pkg::CNT_W-1:0] n_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
      n_r <= '0;
    end else if (rd_vld_r) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= sum_r[i] + csac_pkg::SUM_W'(mem_q[(2 - i) * csac_pkg::CHAN_W +:
                                                     csac_pkg::CHAN_W]);
      end
      n_r <= n_r + 1'b1;
    end
  end

  // Restoring divider, one quotient bit per cycle for all three channels
  logic [csac_pkg::SUM_W-1:0]  rem_r [3];
  logic [csac_pkg::CHAN_W-1:0] quo_r [3];
  logic [csac_pkg::SUM_W-1:0]  dvs_r;
  logic [csac_pkg::STEP_W-1:0] step_r;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      for (int i = 0; i < 3; i++) rem_r[i] <= sum_r[i];
      dvs_r  <= csac_pkg::SUM_W'(n_r) << (csac_pkg::CHAN_W - 1);
      step_r <= csac_pkg::STEP_W'(csac_pkg::CHAN_W - 1);
    end else if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        if (rem_r[i] >= dvs_r) begin
          rem_r[i] <= rem_r[i] - dvs_r;
          quo_r[i] <= {quo_r[i][csac_pkg::CHAN_W-2:0], 1'b1};
        end else begin
          quo_r[i] <= {quo_r[i][csac_pkg::CHAN_W-2:0], 1'b0};
        end
      end
      dvs_r  <= dvs_r >> 1;
      step_r <= step_r - 1'b1;
    end
  end

  // Status to the controller
  always_comb begin
    sts.clr_last    = (clr_addr_r == csac_pkg::ADDR_W'(csac_pkg::DEPTH - 1));
    sts.is_query    = (op_r == csac_pkg::OP_QUERY);
    sts.in_range    = x_ok && y_ok;
    sts.query_empty = !(x_ok && y_ok) || (size_r == '0);
    sts.scan_last   = (row_r == ey_last_r) && (col_r == ex_last_r);
    sts.div_last    = (step_r == '0);
  end

  // Output register
  logic                        ok_r;
  logic [csac_pkg::CHAN_W-1:0] red_r, green_r, blue_r;
  logic                        avg_ok;

  assign avg_ok = sts.is_query && !sts.query_empty;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      ok_r    <= sts.is_query ? avg_ok : sts.in_range;
      red_r   <= avg_ok ? quo_r[0] : '0;
      green_r <= avg_ok ? quo_r[1] : '0;
      blue_r  <= avg_ok ? quo_r[2] : '0;
    end
  end

  assign out_ok        = ok_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;

  // The divider never starts on an empty region
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_load |-> (n_r != '0))
    else $error("divide started with zero pixel count");

  // Every scanned read lands inside the accumulation window
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (n_r < csac_pkg::CNT_W'(csac_pkg::DEPTH)))
    else $error("pixel count overflow");

endmodule

@@ rtl/core/clipped_square_average_color.sv @@
// Top level of the clipped square average color block.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    opcode, x, y, size, red_in, green_in, blue_in
//   out_     output     out_valid/out_ready  ok, red_out, green_out, blue_out
//   cfg_     input      cfg_we               cfg_index, cfg_data (9 bits)
//
// After reset the pixel store is zeroed one pixel per cycle, all 65536 pixels, with in_ready low.
// A write transaction passes through the evaluate and result states; a query over N clipped pixels
// reads them through the single read port of the pixel store, then runs the 8-step divider.
// The result register frees the input side: a new transaction is taken while a result waits,
// and a finished result holds in the result state until the output slot is free.
`timescale 1ns / 1ps

module clipped_square_average_color (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [csac_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [csac_pkg::COORD_W-1:0]  in_x,
  input  logic [csac_pkg::COORD_W-1:0]  in_y,
  input  logic [csac_pkg::SIZE_W-1:0]   in_size,
  input  logic [csac_pkg::CHAN_W-1:0]   in_red_in,
  input  logic [csac_pkg::CHAN_W-1:0]   in_green_in,
  input  logic [csac_pkg::CHAN_W-1:0]   in_blue_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [csac_pkg::CHAN_W-1:0]   out_red_out,
  output logic [csac_pkg::CHAN_W-1:0]   out_green_out,
  output logic [csac_pkg::CHAN_W-1:0]   out_blue_out
);

  csac_pkg::cmd_t cmd;
  csac_pkg::sts_t sts;

  csac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csac_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_opcode     (in_opcode),
    .in_x          (in_x),
    .in_y          (in_y),
    .in_size       (in_size),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_ok        (out_ok),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
